>>> design/bfa_pkg.sv
// Package for the best-fit block allocator.
// Field widths, reset values, opcodes and controller/datapath structs.
// No dependencies.
package bfa_pkg;

  localparam int OpcodeW   = 1;
  localparam int BlockNumW = 4;
  localparam int AmountW   = 16;
  localparam int LeftoverW = 16;
  localparam int CfgW      = 5;

  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  localparam int MaxBlocksDefault = 16;
  localparam int SizeBitsDefault  = 16;

  typedef enum logic [OpcodeW-1:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic start;
    logic read;
    logic commit;
  } bfa_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic scan_last;
    logic out_free;
  } bfa_status_t;

endpackage

>>> design/bfa_item_if.sv
// Input item channel of the best-fit block allocator.
// Depends on bfa_pkg.
interface bfa_item_if import bfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpcodeW-1:0]   opcode;
  logic [BlockNumW-1:0] block_number;
  logic [AmountW-1:0]   amount;

  modport source (output valid, output opcode, output block_number, output amount,
                  input ready);
  modport sink   (input valid, input opcode, input block_number, input amount,
                  output ready);
endinterface

>>> design/bfa_result_if.sv
// Result channel of the best-fit block allocator.
// Depends on bfa_pkg.
interface bfa_result_if import bfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [BlockNumW-1:0] chosen_block;
  logic [LeftoverW-1:0] leftover;

  modport source (output valid, output granted, output chosen_block, output leftover,
                  input ready);
  modport sink   (input valid, input granted, input chosen_block, input leftover,
                  output ready);
endinterface

>>> design/bfa_cfg_if.sv
// Configuration write channel (blocks_in_use register).
// Depends on bfa_pkg.
interface bfa_cfg_if import bfa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] blocks_in_use;

  modport source (output valid, output blocks_in_use, input ready);
  modport sink   (input valid, input blocks_in_use, output ready);
endinterface

>>> design/best_fit_block_allocator_core.sv
// Top level of the best-fit block allocator: controller plus datapath.
// Depends on bfa_pkg, bfa_item_if, bfa_result_if, bfa_cfg_if, bfa_ctrl, bfa_datapath.
//
//   channel   dir  payload                               transaction
//   item_i    in   opcode, block_number, amount          valid & ready
//   result_o  out  granted, chosen_block, leftover       valid & ready
//   cfg_i     in   blocks_in_use                         valid & ready (always ready)
//
// A load gives no result. A request is accepted, scans n blocks, drains
// and commits, n = min(blocks_in_use, MAX_BLOCKS): the size memory is read one
// block per cycle through its single registered read port during the scan.
// With n = 0 there is no scan and no drain: accept is followed by commit.
// Reset clears all taken flags and sets blocks_in_use to 16; sizes are unset.
// The result register lets a new item be accepted while a result waits;
// a request's commit waits until that register is free.
module best_fit_block_allocator_core import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = MaxBlocksDefault,
  parameter int SIZE_BITS  = SizeBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bfa_item_if.sink     item_i,
  bfa_result_if.source result_o,
  bfa_cfg_if.sink      cfg_i
);

  bfa_cmd_t    cmd;
  bfa_status_t status;
  logic        ready;

  assign item_i.ready = ready;

  bfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_i.valid),
    .item_is_req_i (item_i.opcode == OP_REQUEST),
    .item_ready_o  (ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  bfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .block_number_i (item_i.block_number),
    .amount_i       (item_i.amount),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_i          (cfg_i),
    .result_o       (result_o)
  );

endmodule

>>> design/bfa_ctrl.sv
// Controller state machine of the best-fit block allocator.
// Sequences load, scan, drain and commit; depends on bfa_pkg.
module bfa_ctrl import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        item_is_req_i,
  output logic        item_ready_o,
  input  bfa_status_t status_i,
  output bfa_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept       = ready_q & item_valid_i;
  assign item_ready_o = ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_is_req_i) begin
            cmd_o.start = 1'b1;
            state_d     = status_i.n_zero ? S_FINISH : S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

endmodule

>>> design/bfa_datapath.sv
// Datapath of the best-fit block allocator: size memory, taken flags,
// scan/compare stage, config register and result register. Depends on bfa_pkg.
module bfa_datapath import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = MaxBlocksDefault,
  parameter int SIZE_BITS  = SizeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BlockNumW-1:0] block_number_i,
  input  logic [AmountW-1:0]   amount_i,
  input  bfa_cmd_t             cmd_i,
  output bfa_status_t          status_o,
  bfa_cfg_if.sink              cfg_i,
  bfa_result_if.source         result_o
);

  localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntW = $clog2(MAX_BLOCKS + 1);

  logic [SIZE_BITS-1:0]  mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] taken_q;

  logic [CfgW-1:0]      cfg_q;
  logic [CntW-1:0]      n_active;
  logic [CntW-1:0]      n_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [IdxW-1:0]      idx_q;

  logic                 cmp_v_q;
  logic [IdxW-1:0]      cmp_idx_q;
  logic [SIZE_BITS-1:0] rd_data_q;

  logic                 found_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [SIZE_BITS-1:0] best_left_q;

  logic                 out_valid_q;
  logic                 out_granted_q;
  logic [BlockNumW-1:0] out_block_q;
  logic [LeftoverW-1:0] out_left_q;

  logic                 load_ok;
  logic [IdxW-1:0]      load_addr;
  logic [SIZE_BITS-1:0] cand_left;
  logic                 fits;
  logic                 better;

  always_comb begin
    if (32'(cfg_q) > 32'(MAX_BLOCKS)) begin
      n_active = CntW'(MAX_BLOCKS);
    end else begin
      n_active = CntW'(cfg_q);
    end
  end

  assign load_ok   = cmd_i.load && (32'(block_number_i) < 32'(MAX_BLOCKS));
  assign load_addr = IdxW'(block_number_i);

  assign cand_left = rd_data_q - amt_q;
  assign fits      = cmp_v_q && !taken_q[cmp_idx_q] && (rd_data_q >= amt_q);
  assign better    = fits && (!found_q || (cand_left < best_left_q));

  assign status_o.n_zero    = (n_active == '0);
  assign status_o.scan_last = (CntW'(idx_q) == (n_q - CntW'(1)));
  assign status_o.out_free  = !out_valid_q || result_o.ready;

  assign cfg_i.ready = 1'b1;

  assign result_o.valid        = out_valid_q;
  assign result_o.granted      = out_granted_q;
  assign result_o.chosen_block = out_block_q;
  assign result_o.leftover     = out_left_q;

  // Size memory: one write port (load), one registered read port (scan).
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem[load_addr] <= SIZE_BITS'(amount_i);
    end
    if (cmd_i.read) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      amt_q <= SIZE_BITS'(amount_i);
      n_q   <= n_active;
    end
    if (cmd_i.read) begin
      cmp_idx_q <= idx_q;
    end
    if (cmd_i.start) begin
      best_idx_q  <= '0;
      best_left_q <= '0;
    end else if (better) begin
      best_idx_q  <= cmp_idx_q;
      best_left_q <= cand_left;
    end
    if (cmd_i.commit) begin
      out_granted_q <= found_q;
      out_block_q   <= BlockNumW'(best_idx_q);
      out_left_q    <= LeftoverW'(best_left_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      taken_q     <= '0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.blocks_in_use;
      end
      if (load_ok) begin
        taken_q[load_addr] <= 1'b0;
      end else if (cmd_i.commit && found_q) begin
        taken_q[best_idx_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.read) begin
        idx_q <= idx_q + IdxW'(1);
      end
      cmp_v_q <= cmd_i.read;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
